@@ hdl/b2da_pkg.sv @@
// shared constants for the binary to decimal ascii converter
`timescale 1ns / 1ps

package b2da_pkg;

   localparam int VALUE_WIDTH   = 64;
   localparam int DIGITS        = 20;
   localparam int NIBBLE_WIDTH  = 4;
   localparam int BCD_WIDTH     = DIGITS * NIBBLE_WIDTH;
   localparam int BIT_CNT_WIDTH = $clog2(VALUE_WIDTH);
   localparam int CHAR_WIDTH    = 6;
   localparam int TOTAL_WIDTH   = 5;

   localparam logic [CHAR_WIDTH-1:0]   ASCII_ZERO = 6'd48;
   localparam logic [NIBBLE_WIDTH-1:0] ADJ_LIMIT  = 4'd5;
   localparam logic [NIBBLE_WIDTH-1:0] ADJ_ADD    = 4'd3;

endpackage

@@ hdl/b2da_dabble.sv @@
// one shift-and-add-3 step of the binary to bcd conversion
`timescale 1ns / 1ps

module b2da_dabble (
   input  logic [b2da_pkg::BCD_WIDTH-1:0] bcd_in,
   input  logic                           bit_in,
   output logic [b2da_pkg::BCD_WIDTH-1:0] bcd_out
);

   logic [b2da_pkg::BCD_WIDTH-1:0] adj;

   always_comb begin
      for (int i = 0; i < b2da_pkg::DIGITS; i++) begin
         if (bcd_in[i*b2da_pkg::NIBBLE_WIDTH +: b2da_pkg::NIBBLE_WIDTH] >= b2da_pkg::ADJ_LIMIT) begin
            adj[i*b2da_pkg::NIBBLE_WIDTH +: b2da_pkg::NIBBLE_WIDTH] =
               bcd_in[i*b2da_pkg::NIBBLE_WIDTH +: b2da_pkg::NIBBLE_WIDTH] + b2da_pkg::ADJ_ADD;
         end else begin
            adj[i*b2da_pkg::NIBBLE_WIDTH +: b2da_pkg::NIBBLE_WIDTH] =
               bcd_in[i*b2da_pkg::NIBBLE_WIDTH +: b2da_pkg::NIBBLE_WIDTH];
         end
      end
   end

   // top digit never overflows: a 64-bit value fits in 20 digits
   assign bcd_out = {adj[b2da_pkg::BCD_WIDTH-2:0], bit_in};

endmodule

@@ hdl/binary_to_decimal_ascii.sv @@
// top level: sequencer around the shared bcd step unit, with output register
`timescale 1ns / 1ps

// Converts one unsigned 64-bit value per request into its decimal text,
// one ascii digit per response, most significant first, no leading zeros.
// Zero gives the single digit '0'. Every response carries the digit count
// of the whole value and last is set on the final digit.
// Request channel: req_valid / req_stall / req_value. req_stall is high
// whenever a value is being converted or its digits are still being sent.
// Response channel: rsp_valid / rsp_stall and the digit fields, held in an
// output register; a stalled response holds and the sequencer waits.
// Sequence: one shift-and-add-3 step per input bit, then leading zeros
// are dropped one digit at a time, then one digit per cycle while the
// receiver takes them. A new request is taken only once the last digit
// of the previous value is registered.
// Reset (synchronous, active high) returns to idle and drops any
// response not yet taken.

module binary_to_decimal_ascii (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [b2da_pkg::VALUE_WIDTH-1:0] req_value,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [b2da_pkg::CHAR_WIDTH-1:0]  rsp_digit_char,
   output logic [b2da_pkg::TOTAL_WIDTH-1:0] rsp_digit_total,
   output logic                            rsp_last
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_TRIM,
      ST_EMIT
   } state_type;

   localparam int NW = b2da_pkg::NIBBLE_WIDTH;
   localparam int BW = b2da_pkg::BCD_WIDTH;

   state_type                              state_ff;
   logic [b2da_pkg::VALUE_WIDTH-1:0]       shift_ff;
   logic [BW-1:0]                          bcd_ff;
   logic [BW-1:0]                          bcd_in;
   logic [b2da_pkg::BIT_CNT_WIDTH-1:0]     bit_cnt_ff;
   logic [b2da_pkg::TOTAL_WIDTH-1:0]       count_ff;
   logic [b2da_pkg::TOTAL_WIDTH-1:0]       remain_ff;
   logic                                   rsp_valid_ff;
   logic [b2da_pkg::CHAR_WIDTH-1:0]        rsp_char_ff;
   logic [b2da_pkg::TOTAL_WIDTH-1:0]       rsp_total_ff;
   logic                                   rsp_last_ff;
   logic [NW-1:0]                          top_digit;
   logic                                   out_free;

   b2da_dabble u_dabble (
      .bcd_in  (bcd_ff),
      .bit_in  (shift_ff[b2da_pkg::VALUE_WIDTH-1]),
      .bcd_out (bcd_in)
   );

   assign top_digit = bcd_ff[BW-1 -: NW];
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         bit_cnt_ff   <= '0;
         count_ff     <= '0;
         remain_ff    <= '0;
      end else begin
         // output register refills from the emit state, else empties once taken
         if (state_ff == ST_EMIT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  shift_ff   <= req_value;
                  bcd_ff     <= '0;
                  bit_cnt_ff <= '0;
                  state_ff   <= ST_CONV;
               end
            end
            ST_CONV: begin
               bcd_ff     <= bcd_in;
               shift_ff   <= {shift_ff[b2da_pkg::VALUE_WIDTH-2:0], 1'b0};
               bit_cnt_ff <= bit_cnt_ff + 1'b1;
               if (bit_cnt_ff == b2da_pkg::BIT_CNT_WIDTH'(b2da_pkg::VALUE_WIDTH - 1)) begin
                  count_ff <= b2da_pkg::TOTAL_WIDTH'(b2da_pkg::DIGITS);
                  state_ff <= ST_TRIM;
               end
            end
            ST_TRIM: begin
               // drop leading zeros, always keeping at least one digit
               if (top_digit == '0 && count_ff != b2da_pkg::TOTAL_WIDTH'(1)) begin
                  bcd_ff   <= {bcd_ff[BW-NW-1:0], {NW{1'b0}}};
                  count_ff <= count_ff - 1'b1;
               end else begin
                  remain_ff <= count_ff;
                  state_ff  <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_char_ff  <= b2da_pkg::ASCII_ZERO +
                                  {{(b2da_pkg::CHAR_WIDTH-NW){1'b0}}, top_digit};
                  rsp_total_ff <= count_ff;
                  rsp_last_ff  <= (remain_ff == b2da_pkg::TOTAL_WIDTH'(1));
                  bcd_ff       <= {bcd_ff[BW-NW-1:0], {NW{1'b0}}};
                  remain_ff    <= remain_ff - 1'b1;
                  if (remain_ff == b2da_pkg::TOTAL_WIDTH'(1)) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_digit_char  = rsp_char_ff;
   assign rsp_digit_total = rsp_total_ff;
   assign rsp_last        = rsp_last_ff;

endmodule

@@ dv/binary_to_decimal_ascii_tb.sv @@
// testbench for the binary to decimal ascii converter: driver, digit predictor and checker
`timescale 1ns / 1ps

module binary_to_decimal_ascii_tb;

   typedef struct packed {
      logic [b2da_pkg::CHAR_WIDTH-1:0]  ch;
      logic [b2da_pkg::TOTAL_WIDTH-1:0] total;
      logic                             last;
   } digit_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_mode_type;

   localparam logic [b2da_pkg::VALUE_WIDTH-1:0] VALUE_MAX = '1;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_stall;
   logic [b2da_pkg::VALUE_WIDTH-1:0] req_value = '0;
   logic                             rsp_valid;
   logic                             rsp_stall = 1'b0;
   logic [b2da_pkg::CHAR_WIDTH-1:0]  rsp_digit_char;
   logic [b2da_pkg::TOTAL_WIDTH-1:0] rsp_digit_total;
   logic                             rsp_last;

   logic [b2da_pkg::VALUE_WIDTH-1:0] values_to_send[$];
   digit_type                        digit_expect[$];
   int                               err_count = 0;
   int                               burst_left = 4;
   int                               gap_left = 0;
   int                               stall_phase = 0;
   stall_mode_type                   stall_mode = STALL_NONE;

   binary_to_decimal_ascii u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_digit_char  (rsp_digit_char),
      .rsp_digit_total (rsp_digit_total),
      .rsp_last        (rsp_last)
   );

   always #4 clock = ~clock;

   function automatic logic [b2da_pkg::VALUE_WIDTH-1:0] ten_to_the(input int n);
      logic [b2da_pkg::VALUE_WIDTH-1:0] p;
      p = 64'd1;
      for (int i = 0; i < n; i++) p = p * 64'd10;
      return p;
   endfunction

   // queue up the digits of one value, most significant first
   function automatic void expand_to_digits(input logic [b2da_pkg::VALUE_WIDTH-1:0] value);
      logic [b2da_pkg::NIBBLE_WIDTH-1:0] rev[b2da_pkg::DIGITS];
      logic [b2da_pkg::VALUE_WIDTH-1:0]  v;
      int                                n;
      int                                k;
      digit_type                         d;
      v = value;
      n = 0;
      do begin
         rev[n] = b2da_pkg::NIBBLE_WIDTH'(v % 64'd10);
         n++;
         v = v / 64'd10;
      end while (v != 0);
      for (k = 0; k < n; k++) begin
         d.ch    = b2da_pkg::ASCII_ZERO + b2da_pkg::CHAR_WIDTH'(rev[n-1-k]);
         d.total = b2da_pkg::TOTAL_WIDTH'(n);
         d.last  = (k == n - 1);
         digit_expect.push_back(d);
      end
   endfunction

   // request driver: bursts of requests with random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) expand_to_digits(req_value);
         if (gap_left > 0) begin
            gap_left  <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (values_to_send.size() > 0) begin
            req_value <= values_to_send.pop_front();
            req_valid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 10);
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 120);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response checker and receiver stall pattern
   always @(posedge clock) begin : monitor
      digit_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (digit_expect.size() == 0) begin
               $display("%0t: unexpected digit, expected none, actual char %0d total %0d last %0d",
                        $time, rsp_digit_char, rsp_digit_total, rsp_last);
               err_count++;
            end else begin
               want = digit_expect.pop_front();
               if (rsp_digit_char !== want.ch) begin
                  $display("%0t: digit_char mismatch, expected %0d actual %0d",
                           $time, want.ch, rsp_digit_char);
                  err_count++;
               end
               if (rsp_digit_total !== want.total) begin
                  $display("%0t: digit_total mismatch, expected %0d actual %0d",
                           $time, want.total, rsp_digit_total);
                  err_count++;
               end
               if (rsp_last !== want.last) begin
                  $display("%0t: last mismatch, expected %0d actual %0d",
                           $time, want.last, rsp_last);
                  err_count++;
               end
            end
         end
         stall_phase <= stall_phase + 1;
         if (stall_phase % 256 == 0) stall_mode <= stall_mode_type'($urandom_range(0, 3));
         case (stall_mode)
            STALL_NONE:     rsp_stall <= 1'b0;
            STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:    rsp_stall <= ($urandom_range(0, 3) != 0);
            STALL_PERIODIC: rsp_stall <= (stall_phase % 7 < 3);
            default:        rsp_stall <= 1'b0;
         endcase
      end
   end

   initial begin : stimulus
      logic [b2da_pkg::VALUE_WIDTH-1:0] lo;
      logic [b2da_pkg::VALUE_WIDTH-1:0] hi;
      logic [b2da_pkg::VALUE_WIDTH-1:0] rnd;
      int                               n;
      int                               kind;

      // boundaries of the digit count, zero and the largest value
      values_to_send.push_back(64'd0);
      values_to_send.push_back(64'd1);
      values_to_send.push_back(64'd9);
      values_to_send.push_back(64'd10);
      values_to_send.push_back(64'd99);
      values_to_send.push_back(64'd100);
      values_to_send.push_back(64'd9999);
      values_to_send.push_back(64'd10000);
      values_to_send.push_back(64'd999999999999);
      values_to_send.push_back(ten_to_the(15));
      values_to_send.push_back(ten_to_the(19) - 64'd1);
      values_to_send.push_back(ten_to_the(19));
      values_to_send.push_back(64'h8000_0000_0000_0000);
      values_to_send.push_back(64'h7fff_ffff_ffff_ffff);
      values_to_send.push_back(64'h0000_0001_0000_0000);
      values_to_send.push_back(64'h0000_0000_ffff_ffff);
      values_to_send.push_back(VALUE_MAX);
      values_to_send.push_back(VALUE_MAX - 64'd1);
      values_to_send.push_back(64'd12345678901234567890);
      values_to_send.push_back(64'haaaa_aaaa_aaaa_aaaa);
      values_to_send.push_back(64'h5555_5555_5555_5555);

      repeat (380) begin
         kind = $urandom_range(0, 9);
         rnd  = {$urandom, $urandom};
         if (kind <= 6) begin
            // uniform over digit counts, random value of that length
            n  = $urandom_range(1, b2da_pkg::DIGITS);
            lo = (n == 1) ? 64'd0 : ten_to_the(n - 1);
            hi = (n == b2da_pkg::DIGITS) ? VALUE_MAX : ten_to_the(n) - 64'd1;
            values_to_send.push_back(lo + rnd % (hi - lo + 64'd1));
         end else if (kind == 7) begin
            values_to_send.push_back(rnd);
         end else if (kind == 8) begin
            n = $urandom_range(1, b2da_pkg::DIGITS - 1);
            values_to_send.push_back(ten_to_the(n) + 64'($urandom_range(0, 2)) - 64'd1);
         end else if ($urandom_range(0, 1) == 0) begin
            values_to_send.push_back(64'($urandom_range(0, 30)));
         end else begin
            values_to_send.push_back(VALUE_MAX - 64'($urandom_range(0, 1000)));
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock);
      while (values_to_send.size() != 0 || req_valid || digit_expect.size() != 0);
      repeat (120) @(posedge clock);

      if (err_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin : watchdog
      #10_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
